>>> hdl/bba_pkg.sv
package bba_pkg;

    localparam int NUM_BLOCKS = 32;
    localparam int MAX_FILES = 32;
    localparam int RESULT_CAP = 31;

    localparam int SIZE_W = 6;
    localparam int STATUS_W = 2;
    localparam int BLOCK_NUMBER_W = 5;
    localparam int LOGICAL_NUMBER_W = 5;

    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int FREE_W = $clog2(NUM_BLOCKS + 1);
    localparam int FILE_W = $clog2(MAX_FILES + 1);
    localparam int CMP_W = (SIZE_W > FREE_W) ? SIZE_W : FREE_W;

    typedef logic [BLK_W-1:0] blk_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic en;
        blk_t addr;
        logic data;
    } map_wr_t;

endpackage

>>> hdl/bitmap_block_allocator.sv
// A refused request or an empty grant gives its single result in the cycle after the transfer.
// A grant scans the block map memory from block 0, one entry per cycle, through its registered
// read port: each free block found passes through the pending and result registers before it is shown,
// and busy stays high until the last block of the request is given.
// After reset the map is cleared one entry a cycle, and busy stays high until all 32 entries are cleared.
// Results are shown for one cycle each and the receiver cannot stall them.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [SIZE_W-1:0]           request_size,
    output logic                        strobe,
    output logic [STATUS_W-1:0]         status,
    output logic [BLOCK_NUMBER_W-1:0]   block_number,
    output logic [LOGICAL_NUMBER_W-1:0] logical_number,
    output logic                        last
);

    map_wr_t map_wr;
    blk_t    map_raddr;
    logic    map_rdata;

    bba_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request_size   (request_size),
        .strobe         (strobe),
        .status         (status),
        .block_number   (block_number),
        .logical_number (logical_number),
        .last           (last),
        .map_wr         (map_wr),
        .map_raddr      (map_raddr),
        .map_rdata      (map_rdata)
    );

    bba_map_ram u_map (
        .clk   (clk),
        .wr    (map_wr),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

endmodule

>>> hdl/bba_map_ram.sv
module bba_map_ram
    import bba_pkg::*;
(
    input  logic    clk,
    input  map_wr_t wr,
    input  blk_t    raddr,
    output logic    rdata
);

    logic mem [NUM_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/bba_ctrl.sv
module bba_ctrl
    import bba_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [SIZE_W-1:0]           request_size,
    output logic                        strobe,
    output logic [STATUS_W-1:0]         status,
    output logic [BLOCK_NUMBER_W-1:0]   block_number,
    output logic [LOGICAL_NUMBER_W-1:0] logical_number,
    output logic                        last,
    output map_wr_t                     map_wr,
    output blk_t                        map_raddr,
    input  logic                        map_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    blk_t                        addr_reg, addr_next;
    blk_t                        pend_addr_reg, pend_addr_next;
    logic                        pend_reg, pend_next;
    logic [FREE_W-1:0]           free_reg, free_next;
    logic [FILE_W-1:0]           files_reg, files_next;
    logic [SIZE_W-1:0]           size_reg, size_next;
    logic [LOGICAL_NUMBER_W-1:0] given_reg, given_next;
    logic                        strobe_reg, strobe_next;
    status_t                     status_reg, status_next;
    logic [BLOCK_NUMBER_W-1:0]   block_reg, block_next;
    logic [LOGICAL_NUMBER_W-1:0] logical_reg, logical_next;
    logic                        last_reg, last_next;

    logic accept;
    logic table_full;
    logic no_space;
    logic hit;
    logic hit_last;

    assign accept = start && (state_reg == S_IDLE);
    assign table_full = files_reg >= FILE_W'(MAX_FILES);
    assign no_space = (CMP_W'(request_size) >= CMP_W'(free_reg))
        || (request_size > SIZE_W'(RESULT_CAP));
    assign hit = pend_reg && !map_rdata;
    assign hit_last = hit && ((SIZE_W'(given_reg) + SIZE_W'(1)) == size_reg);

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        pend_addr_next = addr_reg;
        pend_next = 1'b0;
        free_next = free_reg;
        files_next = files_reg;
        size_next = size_reg;
        given_next = given_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        block_next = block_reg;
        logical_next = logical_reg;
        last_next = last_reg;
        map_wr.en = 1'b0;
        map_wr.addr = addr_reg;
        map_wr.data = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                map_wr.en = 1'b1;
                addr_next = addr_reg + BLK_W'(1);
                if (addr_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    block_next = '0;
                    logical_next = '0;
                    last_next = 1'b1;
                    priority if (table_full)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_FULL;
                    end
                    else if (no_space)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_NO_SPACE;
                    end
                    else if (request_size == '0)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_EMPTY;
                        files_next = files_reg + FILE_W'(1);
                    end
                    else
                    begin
                        files_next = files_reg + FILE_W'(1);
                        free_next = free_reg - FREE_W'(request_size);
                        size_next = request_size;
                        given_next = '0;
                        addr_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + BLK_W'(1);
                pend_next = !hit_last;
                if (hit)
                begin
                    map_wr.en = 1'b1;
                    map_wr.addr = pend_addr_reg;
                    map_wr.data = 1'b1;
                    strobe_next = 1'b1;
                    status_next = ST_GRANT;
                    block_next = BLOCK_NUMBER_W'(pend_addr_reg);
                    logical_next = given_reg;
                    last_next = hit_last;
                    given_next = given_reg + LOGICAL_NUMBER_W'(1);
                end
                if (hit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg <= '0;
            pend_reg <= 1'b0;
            free_reg <= FREE_W'(NUM_BLOCKS);
            files_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            pend_reg <= pend_next;
            free_reg <= free_next;
            files_reg <= files_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        size_reg <= size_next;
        given_reg <= given_next;
        status_reg <= status_next;
        block_reg <= block_next;
        logical_reg <= logical_next;
        last_reg <= last_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign map_raddr = addr_reg;
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign block_number = block_reg;
    assign logical_number = logical_reg;
    assign last = last_reg;

endmodule

>>> hdl/bba_checker.sv
module bba_checker
    import bba_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [SIZE_W-1:0]           request_size,
    input logic                        strobe,
    input logic [STATUS_W-1:0]         status,
    input logic [BLOCK_NUMBER_W-1:0]   block_number,
    input logic [LOGICAL_NUMBER_W-1:0] logical_number,
    input logic                        last
);

    // A refusal or an empty grant is always a single, final result.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_GRANT) |-> last)
        else $error("non-grant result without last");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_GRANT) |-> (block_number == '0) && (logical_number == '0))
        else $error("non-grant result carries block fields");

    // A grant that is not yet complete keeps the block busy.
    a_open_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("open grant while not busy");

    // The block may go idle in the same cycle that shows the final result.
    a_open_holds: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> busy || strobe)
        else $error("busy dropped before last result");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

>>> dv/bitmap_block_allocator_tb.sv
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;
    import bba_pkg::*;

    typedef struct packed {
        status_t                     st;
        logic [BLOCK_NUMBER_W-1:0]   blk;
        logic [LOGICAL_NUMBER_W-1:0] lg;
        logic                        lst;
    } alloc_res_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              typed;
        alloc_res_t        res;
    } dir_row_t;

    localparam int NUM_DIRECTED = 13;
    localparam int NUM_RANDOM = 200;
    localparam int DRAIN_CYCLES = 40;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [SIZE_W-1:0]           request_size;
    logic                        strobe;
    logic [STATUS_W-1:0]         status;
    logic [BLOCK_NUMBER_W-1:0]   block_number;
    logic [LOGICAL_NUMBER_W-1:0] logical_number;
    logic                        last;

    alloc_res_t alloc_results_q[$];

    logic [NUM_BLOCKS-1:0] shadow_map;
    int shadow_free;
    int shadow_files;

    int mismatches;
    int requests_sent;
    int blocks_granted;
    int empty_grants;
    int space_refusals;
    int full_refusals;
    bit no_idle;

    // The expected result is typed in only where it follows directly from the reset state.
    dir_row_t dir_rows [NUM_DIRECTED] = '{
        '{6'd63, 1'b1, '{ST_NO_SPACE, 5'd0, 5'd0, 1'b1}},
        '{6'd32, 1'b1, '{ST_NO_SPACE, 5'd0, 5'd0, 1'b1}},
        '{6'd33, 1'b1, '{ST_NO_SPACE, 5'd0, 5'd0, 1'b1}},
        '{6'd0,  1'b1, '{ST_EMPTY,    5'd0, 5'd0, 1'b1}},
        '{6'd1,  1'b1, '{ST_GRANT,    5'd0, 5'd0, 1'b1}},
        '{6'd2,  1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd4,  1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd8,  1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd0,  1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd42, 1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd21, 1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd17, 1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}},
        '{6'd5,  1'b0, '{ST_GRANT,    5'd0, 5'd0, 1'b0}}
    };

    bitmap_block_allocator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request_size   (request_size),
        .strobe         (strobe),
        .status         (status),
        .block_number   (block_number),
        .logical_number (logical_number),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected", alloc_results_q.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input alloc_res_t want);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected st=%0d blk=%0d lg=%0d last=%0d, got st=%0d blk=%0d lg=%0d last=%0d",
                     $realtime, what, want.st, want.blk, want.lg, want.lst,
                     status, block_number, logical_number, last);
        end
    endtask

    task automatic push_result(input status_t st, input int blk, input int lg, input logic lst);
        alloc_res_t r;
        r.st = st;
        r.blk = BLOCK_NUMBER_W'(blk);
        r.lg = LOGICAL_NUMBER_W'(lg);
        r.lst = lst;
        alloc_results_q.push_back(r);
    endtask

    // First-fit on the shadow map; one expected result per block, refusal or empty grant.
    task automatic allocate_first_fit(input logic [SIZE_W-1:0] size);
        int given;
        int want;
        want = int'(size);
        given = 0;
        if (shadow_files >= MAX_FILES)
        begin
            push_result(ST_FULL, 0, 0, 1'b1);
            full_refusals++;
        end
        else if (want >= shadow_free || want > RESULT_CAP)
        begin
            push_result(ST_NO_SPACE, 0, 0, 1'b1);
            space_refusals++;
        end
        else
        begin
            shadow_files++;
            if (want == 0)
            begin
                push_result(ST_EMPTY, 0, 0, 1'b1);
                empty_grants++;
            end
            else
            begin
                for (int b = 0; b < NUM_BLOCKS && given < want; b++)
                begin
                    if (!shadow_map[b])
                    begin
                        shadow_map[b] = 1'b1;
                        push_result(ST_GRANT, b, given, (given + 1 == want));
                        given++;
                    end
                end
                shadow_free -= given;
                blocks_granted += given;
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [SIZE_W-1:0] size, input logic typed,
                                input alloc_res_t typed_res);
        int gap;
        int depth;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        request_size <= size;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        depth = alloc_results_q.size();
        allocate_first_fit(size);
        if (typed)
        begin
            while (alloc_results_q.size() > depth)
                void'(alloc_results_q.pop_back());
            alloc_results_q.push_back(typed_res);
        end
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        int top;
        pick = $urandom_range(0, 9);
        top = (shadow_free - 1 < 3) ? shadow_free - 1 : 3;
        if (top < 0)
            top = 0;
        if (pick < 6)
            return SIZE_W'($urandom_range(0, top));
        else if (pick == 6)
            return SIZE_W'($urandom_range(0, 1) ? shadow_free : shadow_free - 1);
        else
            return SIZE_W'($urandom_range(0, 63));
    endfunction

    always @(posedge clk)
    begin
        alloc_res_t want;
        if (rst_n && strobe)
        begin
            if (alloc_results_q.size() == 0)
            begin
                want = '0;
                report_mismatch("Result with nothing expected", want);
            end
            else
            begin
                want = alloc_results_q.pop_front();
                if (status !== want.st || block_number !== want.blk ||
                    logical_number !== want.lg || last !== want.lst)
                    report_mismatch("Result mismatch", want);
            end
        end
    end

    initial
    begin
        alloc_res_t none;
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        request_size = '0;
        shadow_map = '0;
        shadow_free = NUM_BLOCKS;
        shadow_files = 0;
        mismatches = 0;
        requests_sent = 0;
        blocks_granted = 0;
        empty_grants = 0;
        space_refusals = 0;
        full_refusals = 0;
        no_idle = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(dir_rows[i].size, dir_rows[i].typed, dir_rows[i].res);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 20 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_request(pick_size(), 1'b0, none);
        end
        start <= 1'b0;

        for (int i = 0; i < 4000 && alloc_results_q.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (alloc_results_q.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", alloc_results_q.size());
        end

        $display("Sent %0d requests: %0d blocks granted, %0d empty grants,",
                 requests_sent, blocks_granted, empty_grants);
        $display("%0d refused for space, %0d refused with the file table full, %0d mismatches",
                 space_refusals, full_refusals, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/bba_pkg.sv
hdl/bba_map_ram.sv
hdl/bba_ctrl.sv
hdl/bitmap_block_allocator.sv
hdl/bba_checker.sv
dv/bitmap_block_allocator_tb.sv
